[rtl/mtpc_pkg.sv]
`default_nettype none

package mtpc_pkg;

   localparam int unsigned WordWidth = 32;

   localparam logic [WordWidth-1:0] GoldenMult   = 32'h9E37_79B9;
   localparam logic [WordWidth-1:0] GoldenMask   = 32'hA5A5_A5A5;
   localparam logic [WordWidth-1:0] MurmurInMask = 32'hC3C3_C3C3;
   localparam logic [WordWidth-1:0] MurmurMult1  = 32'h85EB_CA6B;
   localparam logic [WordWidth-1:0] MurmurMult2  = 32'hC2B2_AE35;
   localparam logic [WordWidth-1:0] MurmurOutMask = 32'h5A5A_5A5A;
   localparam logic [WordWidth-1:0] CountMax     = '1;

   localparam logic PatGolden = 1'b0;
   localparam logic PatMurmur = 1'b1;

   localparam logic ActGenerate = 1'b0;
   localparam logic ActCheck    = 1'b1;

   // configuration port
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic        CsrIdxPattern = 1'b0;

   typedef struct packed {
      logic                 action;
      logic [WordWidth-1:0] word_index;
      logic [WordWidth-1:0] read_data;
      logic                 start_of_pass;
      logic                 last_of_pass;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] pattern_word;
      logic                 word_mismatch;
      logic                 pass_ok;
      logic [WordWidth-1:0] mismatch_total;
      logic [WordWidth-1:0] first_bad_index;
      logic [WordWidth-1:0] first_bad_expected;
      logic [WordWidth-1:0] first_bad_actual;
      logic                 pass_complete;
   } rsp_type;

   typedef struct packed {
      logic load;    // capture the input beat and prepare the first hash operand
      logic mul1;    // first multiply
      logic mul2;    // second multiply, murmur pattern only
      logic finish;  // compare, update pass state, load the output register
   } cmd_type;

   typedef struct packed {
      logic pattern_sel;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/mtpc_ctrl.sv]
`default_nettype none

module mtpc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mtpc_pkg::sts_type sts,
   output mtpc_pkg::cmd_type      cmd
);
   import mtpc_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StMul1 = 2'd1;
   localparam logic [1:0] StMul2 = 2'd2;
   localparam logic [1:0] StDone = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StMul1;
            end
         end
         StMul1: begin
            cmd.mul1 = 1'b1;
            state_in = (sts.pattern_sel == PatMurmur) ? StMul2 : StDone;
         end
         StMul2: begin
            cmd.mul2 = 1'b1;
            state_in = StDone;
         end
         StDone: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = StIdle;
            end
         end
      endcase
   end

   assign req_stall = (state_ff != StIdle);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/mtpc_datapath.sv]
`default_nettype none

module mtpc_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mtpc_pkg::req_type                    req_data,
   input  wire mtpc_pkg::cmd_type                    cmd,
   output mtpc_pkg::sts_type                         sts,
   input  wire logic                                 cfg_write,
   input  wire logic                                 cfg_pattern,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output mtpc_pkg::rsp_type                         rsp_data
);
   import mtpc_pkg::*;

   logic                 pattern_sel_ff, pattern_sel_in;
   req_type              item_ff, item_in;
   logic [WordWidth-1:0] work_ff, work_in;

   logic                 pass_flag_ff, pass_flag_in;
   logic [WordWidth-1:0] count_ff, count_in;
   logic [WordWidth-1:0] first_index_ff, first_index_in;
   logic [WordWidth-1:0] first_expected_ff, first_expected_in;
   logic [WordWidth-1:0] first_actual_ff, first_actual_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [WordWidth-1:0] mixed_index;
   logic [WordWidth-1:0] prep_word;
   logic [WordWidth-1:0] mul_a;
   logic [WordWidth-1:0] mul_b;
   logic [WordWidth-1:0] mul_prod;
   logic [WordWidth-1:0] expect_word;
   logic                 bad;

   assign mixed_index = req_data.word_index ^ MurmurInMask;

   always_comb begin
      if (pattern_sel_ff == PatMurmur) begin
         prep_word = mixed_index ^ (mixed_index >> 16);
      end else begin
         prep_word = req_data.word_index ^ (req_data.word_index >> 16);
      end
   end

   // one shared multiplier, low half of the product only
   always_comb begin
      if (cmd.mul2) begin
         mul_a = work_ff ^ (work_ff >> 13);
         mul_b = MurmurMult2;
      end else begin
         mul_a = work_ff;
         mul_b = (pattern_sel_ff == PatMurmur) ? MurmurMult1 : GoldenMult;
      end
   end

   assign mul_prod = WordWidth'(mul_a * mul_b);

   always_comb begin
      if (pattern_sel_ff == PatMurmur) begin
         expect_word = work_ff ^ (work_ff >> 16) ^ MurmurOutMask;
      end else begin
         expect_word = work_ff ^ GoldenMask;
      end
   end

   assign bad = (item_ff.action == ActCheck) && (item_ff.read_data != expect_word);

   always_comb begin
      pattern_sel_in    = cfg_write ? cfg_pattern : pattern_sel_ff;
      item_in           = cmd.load ? req_data : item_ff;
      work_in           = work_ff;
      pass_flag_in      = pass_flag_ff;
      count_in          = count_ff;
      first_index_in    = first_index_ff;
      first_expected_in = first_expected_ff;
      first_actual_in   = first_actual_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         work_in = prep_word;
         if (req_data.start_of_pass) begin
            pass_flag_in      = 1'b1;
            count_in          = '0;
            first_index_in    = '0;
            first_expected_in = '0;
            first_actual_in   = '0;
         end
      end

      if (cmd.mul1 || cmd.mul2) begin
         work_in = mul_prod;
      end

      if (cmd.finish) begin
         if (bad) begin
            if (pass_flag_ff) begin
               first_index_in    = item_ff.word_index;
               first_expected_in = expect_word;
               first_actual_in   = item_ff.read_data;
            end
            pass_flag_in = 1'b0;
            if (count_ff != CountMax) begin
               count_in = count_ff + 1'b1;
            end
         end
         rsp_valid_in                   = 1'b1;
         rsp_data_in.pattern_word       = expect_word;
         rsp_data_in.word_mismatch      = bad;
         rsp_data_in.pass_ok            = pass_flag_in;
         rsp_data_in.mismatch_total     = count_in;
         rsp_data_in.first_bad_index    = first_index_in;
         rsp_data_in.first_bad_expected = first_expected_in;
         rsp_data_in.first_bad_actual   = first_actual_in;
         rsp_data_in.pass_complete      = item_ff.last_of_pass;
      end
   end

   assign sts.pattern_sel = pattern_sel_ff;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_sel_ff    <= PatGolden;
         pass_flag_ff      <= 1'b1;
         count_ff          <= '0;
         first_index_ff    <= '0;
         first_expected_ff <= '0;
         first_actual_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_sel_ff    <= pattern_sel_in;
         pass_flag_ff      <= pass_flag_in;
         count_ff          <= count_in;
         first_index_ff    <= first_index_in;
         first_expected_ff <= first_expected_in;
         first_actual_ff   <= first_actual_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[rtl/memory_test_pattern_checker.sv]
// Memory test pattern checker.
// Input channel (req_*): one beat per memory word, carrying the action
// (generate or check), the word index, the word read back, and the start
// and last markers of a pass. Result channel (rsp_*): one beat per input
// beat with the expected pattern word, the mismatch flag of this word and
// the pass status (pass flag, saturating mismatch count, first mismatch).
// Configuration (csr_*): register 0 at byte address 0 selects the pattern,
// 0 golden-ratio, 1 murmur finalizer. Write it only while the block is idle.
// Steps: an accepted beat goes through load, first multiply and finish with
// the golden-ratio pattern, with a second multiply before finish for murmur,
// on the single shared 32x32 multiplier that the hash steps use one after
// the other. The result is valid in the cycle after the final step.
// The output register holds the result while rsp_stall is high; the next
// input beat is accepted and hashed meanwhile, and waits in its final step
// until the output register frees up.
// Reset clears the pattern select to golden-ratio, sets the pass flag, zeroes
// the count and first-mismatch record, and empties the output register.
`default_nettype none

module memory_test_pattern_checker (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire mtpc_pkg::req_type                        req_data,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output mtpc_pkg::rsp_type                             rsp_data,
   input  wire logic                                     csr_psel,
   input  wire logic                                     csr_penable,
   input  wire logic                                     csr_pwrite,
   input  wire logic [mtpc_pkg::CsrAddrWidth-1:0]        csr_paddr,
   input  wire logic [mtpc_pkg::CsrDataWidth-1:0]        csr_pwdata,
   output logic [mtpc_pkg::CsrDataWidth-1:0]             csr_prdata,
   output logic                                          csr_pready
);
   import mtpc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    cfg_write;
   logic    csr_index;

   assign csr_index  = csr_paddr[CsrAddrWidth-1];
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_index == CsrIdxPattern);

   always_comb begin
      csr_prdata = '0;
      if (csr_index == CsrIdxPattern) begin
         csr_prdata[0] = sts.pattern_sel;
      end
   end

   mtpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtpc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .cfg_write   (cfg_write),
      .cfg_pattern (csr_pwdata[0]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[tb/sv/tb_memory_test_pattern_checker.sv]
module tb_memory_test_pattern_checker;
   timeunit 1ns;
   timeprecision 1ps;

   import mtpc_pkg::*;

   localparam logic [CsrAddrWidth-1:0] PatternAddr = 3'd0;
   localparam logic [CsrAddrWidth-1:0] SpareAddr   = 3'd4;
   localparam int unsigned IdleLimit    = 2000;
   localparam int unsigned PhaseBeats   = 185;
   localparam int unsigned RandomPhases = 8;
   localparam int unsigned DrainCycles  = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   // checker state as the block should hold it
   logic        sel_pattern       = PatGolden;
   logic        pass_flag         = 1'b1;
   logic [31:0] miss_count        = '0;
   logic [31:0] first_index       = '0;
   logic [31:0] bad_expected_word = '0;
   logic [31:0] bad_actual_word   = '0;

   req_type     pending_words[$];
   rsp_type     expected_status[$];
   rsp_type     status_due;
   int unsigned error_count = 0;
   bit          quiet_phase = 1'b0;
   int unsigned send_gap    = 0;
   int unsigned stall_left  = 0;
   int unsigned idle_cycles = 0;

   memory_test_pattern_checker dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] golden_hash(input logic [31:0] idx);
      logic [31:0] v;
      v = idx ^ (idx >> 16);
      v = v * 32'h9E37_79B9;
      return v ^ 32'hA5A5_A5A5;
   endfunction

   function automatic logic [31:0] murmur_hash(input logic [31:0] idx);
      logic [31:0] v;
      v = idx ^ 32'hC3C3_C3C3;
      v = (v ^ (v >> 16)) * 32'h85EB_CA6B;
      v = (v ^ (v >> 13)) * 32'hC2B2_AE35;
      return v ^ (v >> 16) ^ 32'h5A5A_5A5A;
   endfunction

   function automatic logic [31:0] pattern_hash(input logic sel, input logic [31:0] idx);
      return (sel == PatMurmur) ? murmur_hash(idx) : golden_hash(idx);
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic predict_word_status(input req_type beat);
      rsp_type     res;
      logic [31:0] want;
      if (beat.start_of_pass) begin
         pass_flag         = 1'b1;
         miss_count        = '0;
         first_index       = '0;
         bad_expected_word = '0;
         bad_actual_word   = '0;
      end
      want = pattern_hash(sel_pattern, beat.word_index);
      res  = '0;
      if (beat.action == ActCheck && beat.read_data != want) begin
         res.word_mismatch = 1'b1;
         if (pass_flag) begin
            first_index       = beat.word_index;
            bad_expected_word = want;
            bad_actual_word   = beat.read_data;
         end
         pass_flag = 1'b0;
         if (miss_count != CountMax) miss_count++;
      end
      res.pattern_word       = want;
      res.pass_ok            = pass_flag;
      res.mismatch_total     = miss_count;
      res.first_bad_index    = first_index;
      res.first_bad_expected = bad_expected_word;
      res.first_bad_actual   = bad_actual_word;
      res.pass_complete      = beat.last_of_pass;
      expected_status.push_back(res);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // input side: hold the beat while stalled, advance once it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && !req_stall) predict_word_status(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data  <= pending_words.pop_front();
               req_valid <= 1'b1;
               send_gap  = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: check each beat taken, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
               error_count++;
            end else begin
               status_due = expected_status.pop_front();
               compare_field("pattern_word", status_due.pattern_word, rsp_data.pattern_word);
               compare_field("word_mismatch", 32'(status_due.word_mismatch),
                             32'(rsp_data.word_mismatch));
               compare_field("pass_ok", 32'(status_due.pass_ok), 32'(rsp_data.pass_ok));
               compare_field("mismatch_total", status_due.mismatch_total,
                             rsp_data.mismatch_total);
               compare_field("first_bad_index", status_due.first_bad_index,
                             rsp_data.first_bad_index);
               compare_field("first_bad_expected", status_due.first_bad_expected,
                             rsp_data.first_bad_expected);
               compare_field("first_bad_actual", status_due.first_bad_actual,
                             rsp_data.first_bad_actual);
               compare_field("pass_complete", 32'(status_due.pass_complete),
                             32'(rsp_data.pass_complete));
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic csr_access(input bit is_write, input logic [CsrAddrWidth-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (is_write && addr == PatternAddr) sel_pattern = wdata[0];
   endtask

   task automatic verify_pattern_reg();
      logic [31:0] got;
      csr_access(1'b0, PatternAddr, '0, got);
      if (got !== {31'b0, sel_pattern}) begin
         $display("%0t: pattern_select expected %h, got %h", $time, {31'b0, sel_pattern}, got);
         error_count++;
      end
   endtask

   task automatic queue_beat(input logic act, input logic [31:0] idx, input logic [31:0] data,
                             input logic start, input logic last);
      req_type beat;
      beat.action        = act;
      beat.word_index    = idx;
      beat.read_data     = data;
      beat.start_of_pass = start;
      beat.last_of_pass  = last;
      pending_words.push_back(beat);
   endtask

   task automatic queue_directed();
      logic [31:0] h;
      queue_beat(ActGenerate, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0);
      queue_beat(ActGenerate, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_beat(ActGenerate, 32'h0001_0001, 32'h0000_0000, 1'b0, 1'b1);
      queue_beat(ActCheck, 32'h0000_0000, pattern_hash(sel_pattern, 32'h0), 1'b1, 1'b0);
      queue_beat(ActCheck, 32'hFFFF_FFFF, pattern_hash(sel_pattern, '1), 1'b0, 1'b0);
      h = pattern_hash(sel_pattern, 32'd5);
      queue_beat(ActCheck, 32'd5, h ^ 32'h1, 1'b0, 1'b0);
      // later mismatch must leave the first record alone
      h = pattern_hash(sel_pattern, 32'd6);
      queue_beat(ActCheck, 32'd6, ~h, 1'b0, 1'b0);
      queue_beat(ActGenerate, 32'd7, 32'h0000_0000, 1'b0, 1'b0);
      queue_beat(ActCheck, 32'h8000_0000, pattern_hash(sel_pattern, 32'h8000_0000),
                 1'b0, 1'b1);
      queue_beat(ActGenerate, 32'd9, 32'hDEAD_BEEF, 1'b1, 1'b0);
      // clear and record a mismatch on the same beat
      h = pattern_hash(sel_pattern, 32'd12);
      queue_beat(ActCheck, 32'd12, h ^ 32'h8000_0000, 1'b1, 1'b1);
   endtask

   // write pass over a run of words, then read it back with some corruption
   task automatic queue_mem_pass(input int unsigned len, input int unsigned corrupt_pct);
      logic [31:0] base;
      logic [31:0] flip;
      base = $urandom();
      for (int unsigned i = 0; i < len; i++) begin
         queue_beat(ActGenerate, base + i, $urandom(), i == 0, i == len - 1);
      end
      for (int unsigned i = 0; i < len; i++) begin
         flip = '0;
         if ($urandom_range(0, 99) < corrupt_pct) begin
            flip = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : $urandom();
            if (flip == '0) flip = 32'h1;
         end
         queue_beat(ActCheck, base + i, pattern_hash(sel_pattern, base + i) ^ flip,
                    i == 0, i == len - 1);
      end
   endtask

   task automatic queue_noise(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         queue_beat($urandom_range(0, 1), $urandom(), $urandom(),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_status.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      logic [31:0] unused;
      logic [31:0] word;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      verify_pattern_reg();
      csr_access(1'b1, PatternAddr, 32'h0, unused);
      queue_directed();
      drain();

      csr_access(1'b1, PatternAddr, 32'hFFFF_FFFF, unused);
      verify_pattern_reg();
      queue_directed();
      drain();

      // writes outside the register map are dropped
      csr_access(1'b1, SpareAddr, 32'h0, unused);
      verify_pattern_reg();

      for (int unsigned p = 0; p < RandomPhases; p++) begin
         word    = $urandom();
         word[0] = (p % 2 == 0) ? PatGolden : PatMurmur;
         csr_access(1'b1, PatternAddr, word, unused);
         verify_pattern_reg();
         quiet_phase = (p % 4 == 3);
         while (pending_words.size() < PhaseBeats) begin
            if ($urandom_range(0, 99) < 85) begin
               queue_mem_pass($urandom_range(1, 24), $urandom_range(0, 1) ? 0 : 10);
            end else begin
               queue_noise($urandom_range(1, 6));
            end
         end
         drain();
      end

      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[memory_test_pattern_checker.f]
rtl/mtpc_pkg.sv
rtl/mtpc_ctrl.sv
rtl/mtpc_datapath.sv
rtl/memory_test_pattern_checker.sv
tb/sv/tb_memory_test_pattern_checker.sv
